// File: rtl/pis_pkg.sv
// Shared constants, types and table functions of the phase-shifting interferometry pixel block.
`timescale 1ns / 1ps
`default_nettype none
package pis_pkg;

   localparam int SAMPLE_BITS_DEF     = 16;
   localparam int PHASE_FRAC_BITS_DEF = 13;
   localparam int NUM_SAMPLES         = 7;
   localparam int STEP_W              = 3;
   localparam int PHASE_W             = 16;
   localparam int AMP_W               = 30;
   localparam int BG_W                = 18;
   localparam int RSP_W               = PHASE_W + AMP_W + BG_W;
   localparam int ANG_FRAC            = 60;
   localparam int CORDIC_ITERS        = 60;
   localparam int SQRT_ITERS          = AMP_W;
   localparam int SQ_CAP_BIT          = 2 * AMP_W;
   localparam int NORM_MSB            = 58;
   localparam int AMP_SCALE           = 1000;
   localparam int SCALE_W             = 10;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_AW            = $clog2(QUEUE_DEPTH);

   localparam logic [STEP_W-1:0] STEP_3     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_4     = 3'd4;
   localparam logic [STEP_W-1:0] STEP_5     = 3'd5;
   localparam logic [STEP_W-1:0] STEP_6     = 3'd6;
   localparam logic [STEP_W-1:0] STEP_7     = 3'd7;
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_4;

   localparam logic [AMP_W-1:0] AMP_MAX = '1;
   localparam logic [BG_W-1:0]  BG_MAX  = '1;

   localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;

   typedef enum logic [1:0] {
      OFF_NONE,
      OFF_POS,
      OFF_NEG
   } off_type;

   // Restoring shift-subtract division, used only to build constant tables.
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      int          b;
      q = '0;
      r = '0;
      for (b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Arctangent of 2^-idx in Q60 radians, from the alternating series in Q62.
   function automatic logic [63:0] atan_q60(input int idx);
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] k;
      int          j;
      if (idx == 0) begin
         return 64'((PI_Q60 + 64'sd2) >>> 2);
      end
      p   = 64'd1 << (62 - idx);
      sum = '0;
      k   = '0;
      for (j = 0; j < 32; j++) begin
         if (p != 64'd0) begin
            if (!k[0]) begin
               sum = sum + udiv64(p, (k << 1) + 64'd1);
            end else begin
               sum = sum - udiv64(p, (k << 1) + 64'd1);
            end
            if (2 * idx >= 64) begin
               p = '0;
            end else begin
               p = p >> (2 * idx);
            end
            k = k + 64'd1;
         end
      end
      return (sum + 64'd2) >> 2;
   endfunction

endpackage
`default_nettype wire

// File: rtl/pis_front.sv
// Front end: step count register and per-mode numerator, denominator and background.
`timescale 1ns / 1ps
`default_nettype none
module pis_front #(
   parameter int SAMPLE_BITS = pis_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [pis_pkg::STEP_W-1:0]                    csr_data,
   input  logic [pis_pkg::NUM_SAMPLES*SAMPLE_BITS-1:0]   samples,
   output logic signed [SAMPLE_BITS+3:0]                 num,
   output logic signed [SAMPLE_BITS+3:0]                 den,
   output logic [pis_pkg::BG_W-1:0]                      bg,
   output logic                                          mode7
);
   import pis_pkg::*;

   localparam int NW    = SAMPLE_BITS + 4;
   localparam int BW2   = SAMPLE_BITS + 3;
   localparam int BGV_W = SAMPLE_BITS + 2;
   localparam int T3_W  = SAMPLE_BITS + 2;
   localparam int V3_W  = T3_W + 2;
   localparam int N3    = SAMPLE_BITS + 5;
   localparam int P3_W  = V3_W + N3;
   localparam int BGX   = (BGV_W > BG_W) ? BGV_W : BG_W;
   localparam longint unsigned M3_L = ((64'd1 << N3) + 64'd2) / 3;
   localparam logic [N3-1:0] M3 = N3'(M3_L);

   logic [STEP_W-1:0]     step_ff;
   logic [STEP_W-1:0]     step_in;
   logic signed [NW-1:0]  ss [NUM_SAMPLES];
   logic [BW2-1:0]        bg2;
   logic [BW2:0]          bgr;
   logic                  mode3;
   logic [T3_W-1:0]       t3;
   logic [V3_W-1:0]       v3;
   logic [P3_W-1:0]       p3;
   logic [BGV_W-1:0]      bgv;
   logic [BGX-1:0]        bgx;

   assign csr_ready = 1'b1;
   assign step_in   = csr_valid ? csr_data : step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_SAMPLES; k++) begin
         ss[k] = signed'(NW'(samples[k*SAMPLE_BITS +: SAMPLE_BITS]));
      end
   end

   always_comb begin
      num   = '0;
      den   = '0;
      bg2   = '0;
      mode3 = 1'b0;
      mode7 = 1'b0;
      unique case (step_ff)
         STEP_7: begin
            num   = NW'(4 * ss[1] - 8 * ss[3] + 4 * ss[5]);
            den   = NW'(-ss[0] + 7 * ss[2] - 7 * ss[4] + ss[6]);
            bg2   = BW2'(ss[0] + ss[1] + ss[2] + ss[4] + ss[5] + ss[6] + 2 * ss[3]);
            mode7 = 1'b1;
         end
         STEP_6: begin
            num = NW'(-3 * ss[1] + 4 * ss[3] - ss[5]);
            den = NW'(ss[0] - 4 * ss[2] + 3 * ss[4]);
            bg2 = BW2'(ss[0] + ss[1] + ss[4] + ss[5] + 2 * (ss[2] + ss[3]));
         end
         STEP_5: begin
            num = NW'(2 * (ss[1] - ss[3]));
            den = NW'(2 * ss[2] - ss[4] - ss[0]);
            bg2 = BW2'(ss[0] + ss[4] + 2 * (ss[1] + ss[2] + ss[3]));
         end
         STEP_4: begin
            num = NW'(ss[1] - ss[3]);
            den = NW'(ss[2] - ss[0]);
            bg2 = BW2'(2 * (ss[0] + ss[1] + ss[2] + ss[3]));
         end
         default: begin
            num   = NW'(ss[2] - ss[1]);
            den   = NW'(ss[0] - ss[1]);
            mode3 = 1'b1;
         end
      endcase
   end

   // Three-step background is (4t + 1) / 3, done as a reciprocal multiply.
   always_comb begin
      t3  = T3_W'(ss[0] + ss[1] + ss[2]);
      v3  = {t3, 2'b01};
      p3  = P3_W'(v3) * P3_W'(M3);
      bgr = {1'b0, bg2} + (BW2 + 1)'(1);
      if (mode3) begin
         bgv = p3[N3 +: BGV_W];
      end else begin
         bgv = BGV_W'(bgr[BW2:1]);
      end
      bgx = BGX'(bgv);
      bg  = (bgx > BGX'(BG_MAX)) ? BG_MAX : bgx[BG_W-1:0];
   end

endmodule
`default_nettype wire

// File: rtl/pis_fifo.sv
// Short register queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
`default_nettype none
module pis_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import pis_pkg::*;

   logic [WIDTH-1:0]    slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff;
   logic [QUEUE_AW-1:0] rd_ff;
   logic [QUEUE_AW:0]   cnt_ff;
   logic                push;
   logic                pop;

   assign push_ready = cnt_ff != (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = slot_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + QUEUE_AW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + (QUEUE_AW + 1)'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - (QUEUE_AW + 1)'(1);
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/pis_back.sv
// Back end: pipelined CORDIC arctangent, pipelined integer square root and output register.
`timescale 1ns / 1ps
`default_nettype none
module pis_back #(
   parameter int SAMPLE_BITS     = pis_pkg::SAMPLE_BITS_DEF,
   parameter int PHASE_FRAC_BITS = pis_pkg::PHASE_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic signed [SAMPLE_BITS+3:0]        in_num,
   input  logic signed [SAMPLE_BITS+3:0]        in_den,
   input  logic [pis_pkg::BG_W-1:0]             in_bg,
   input  logic                                 in_mode7,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [pis_pkg::PHASE_W-1:0]          out_phase,
   output logic [pis_pkg::AMP_W-1:0]            out_amp,
   output logic [pis_pkg::BG_W-1:0]             out_bg
);
   import pis_pkg::*;

   localparam int NW   = SAMPLE_BITS + 4;
   localparam int MW   = NW - 1;
   localparam int AW   = MW + SCALE_W;
   localparam int SQW  = 2 * AW + 1;
   localparam int SQX  = (SQW > SQ_CAP_BIT + 1) ? SQW : SQ_CAP_BIT + 1;
   localparam int SH   = ANG_FRAC - PHASE_FRAC_BITS;
   localparam int LAST = CORDIC_ITERS + 1;
   localparam int RW   = AMP_W + 2;
   localparam logic [63:0] HALF = 64'd1 << (SH - 1);

   logic en;

   logic                 vld1_ff;
   logic signed [NW-1:0] x1_ff;
   logic signed [NW-1:0] y1_ff;
   logic [AW-1:0]        a1_ff;
   logic [AW-1:0]        b1_ff;
   off_type              off1_ff;
   logic                 zero1_ff;
   logic                 m71_ff;
   logic [BG_W-1:0]      bg1_ff;
   logic signed [NW-1:0] absn;
   logic signed [NW-1:0] absd;
   logic                 negx;
   off_type              off1_in;

   logic [2*AW-1:0]      a2_ff;
   logic [2*AW-1:0]      b2_ff;
   logic                 m72_ff;
   logic signed [NW-1:0] ay;
   logic [MW-1:0]        mag;
   logic [5:0]           msb;
   logic [5:0]           nsh;
   logic signed [63:0]   z0_in;
   logic [SQX-1:0]       sq;

   logic                 vld_ff  [0:LAST];
   logic                 zero_ff [0:LAST];
   logic [BG_W-1:0]      bg_ff   [0:LAST];
   logic signed [63:0]   x_ff    [0:CORDIC_ITERS];
   logic signed [63:0]   y_ff    [0:CORDIC_ITERS];
   logic signed [63:0]   z_ff    [0:CORDIC_ITERS];
   logic                 sat_ff  [1:LAST];
   logic [AMP_W-1:0]     root_ff [1:LAST];
   logic [RW-1:0]        rem_ff  [1:SQRT_ITERS];
   logic [SQ_CAP_BIT-1:0] sqv_ff [1:SQRT_ITERS];

   logic [63:0]          abs_ff;
   logic                 neg_ff;
   logic signed [63:0]   ang;
   logic [63:0]          rr;
   logic [PHASE_W-1:0]   r16;

   logic                 out_valid_ff;
   logic [PHASE_W-1:0]   out_phase_ff;
   logic [AMP_W-1:0]     out_amp_ff;
   logic [BG_W-1:0]      out_bg_ff;

   assign en        = !out_valid_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = out_valid_ff;
   assign out_phase = out_phase_ff;
   assign out_amp   = out_amp_ff;
   assign out_bg    = out_bg_ff;

   // Stage one: magnitudes, scaling and half-plane fold.
   always_comb begin
      absn    = in_num[NW-1] ? -in_num : in_num;
      absd    = in_den[NW-1] ? -in_den : in_den;
      negx    = in_den[NW-1];
      off1_in = OFF_NONE;
      if (negx) begin
         off1_in = in_num[NW-1] ? OFF_NEG : OFF_POS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff    <= negx ? -in_den : in_den;
         y1_ff    <= negx ? -in_num : in_num;
         a1_ff    <= in_mode7 ? AW'(absn[MW-1:0]) * AW'(AMP_SCALE) : AW'(absn[MW-1:0]);
         b1_ff    <= in_mode7 ? AW'(absd[MW-1:0]) * AW'(AMP_SCALE) : AW'(absd[MW-1:0]);
         off1_ff  <= off1_in;
         zero1_ff <= (in_num == '0) && (in_den == '0);
         m71_ff   <= in_mode7;
         bg1_ff   <= in_bg;
      end
   end

   // Stage two: squares and normalization of the vector.
   always_comb begin
      ay  = y1_ff[NW-1] ? -y1_ff : y1_ff;
      mag = (x1_ff > ay) ? x1_ff[MW-1:0] : ay[MW-1:0];
      msb = '0;
      for (int i = 0; i < MW; i++) begin
         if (mag[i]) begin
            msb = 6'(i);
         end
      end
      nsh = 6'(NORM_MSB) - msb;
      case (off1_ff)
         OFF_POS: z0_in = PI_Q60;
         OFF_NEG: z0_in = -PI_Q60;
         default: z0_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_ff      <= (2 * AW)'(a1_ff) * (2 * AW)'(a1_ff);
         b2_ff      <= (2 * AW)'(b1_ff) * (2 * AW)'(b1_ff);
         m72_ff     <= m71_ff;
         x_ff[0]    <= 64'(x1_ff) <<< nsh;
         y_ff[0]    <= 64'(y1_ff) <<< nsh;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= zero1_ff;
         bg_ff[0]   <= bg1_ff;
      end
   end

   // Sum of squares, den square halved in mode 7; from the cap up, the amplitude saturates.
   always_comb begin
      sq = SQX'(a2_ff) + (m72_ff ? SQX'(b2_ff >> 1) : SQX'(b2_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff[1]  <= |sq[SQX-1:SQ_CAP_BIT];
         sqv_ff[1]  <= sq[SQ_CAP_BIT-1:0];
         root_ff[1] <= '0;
         rem_ff[1]  <= '0;
      end
   end

   genvar gk;
   for (gk = 1; gk <= LAST; gk++) begin : g_carry
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[gk] <= 1'b0;
         end else if (en) begin
            vld_ff[gk] <= vld_ff[gk-1];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[gk] <= zero_ff[gk-1];
            bg_ff[gk]   <= bg_ff[gk-1];
         end
      end
      if (gk >= 2) begin : g_sat
         always_ff @(posedge clock) begin
            if (en) begin
               sat_ff[gk] <= sat_ff[gk-1];
            end
         end
      end
      if (gk >= SQRT_ITERS + 2) begin : g_root
         always_ff @(posedge clock) begin
            if (en) begin
               root_ff[gk] <= root_ff[gk-1];
            end
         end
      end
   end

   genvar gi;
   for (gi = 0; gi < CORDIC_ITERS; gi++) begin : g_cordic
      localparam logic signed [63:0] ATAN_C = signed'(atan_q60(gi));
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      always_comb begin
         dx = (y_ff[gi] >= 0) ? (y_ff[gi] >>> gi) : -((-y_ff[gi]) >>> gi);
         dy = x_ff[gi] >>> gi;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[gi] > 0) begin
               x_ff[gi+1] <= x_ff[gi] + dx;
               y_ff[gi+1] <= y_ff[gi] - dy;
               z_ff[gi+1] <= z_ff[gi] + ATAN_C;
            end else begin
               x_ff[gi+1] <= x_ff[gi] - dx;
               y_ff[gi+1] <= y_ff[gi] + dy;
               z_ff[gi+1] <= z_ff[gi] - ATAN_C;
            end
         end
      end
   end

   genvar gj;
   for (gj = 0; gj < SQRT_ITERS; gj++) begin : g_sqrt
      logic [RW+1:0] rem4;
      logic [RW+1:0] trial;
      logic          fits;
      always_comb begin
         rem4  = {rem_ff[gj+1], sqv_ff[gj+1][SQ_CAP_BIT-1-2*gj -: 2]};
         trial = {2'b00, root_ff[gj+1], 2'b01};
         fits  = rem4 >= trial;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[gj+2] <= {root_ff[gj+1][AMP_W-2:0], fits};
         end
      end
      if (gj < SQRT_ITERS - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[gj+2] <= fits ? RW'(rem4 - trial) : RW'(rem4);
               sqv_ff[gj+2] <= sqv_ff[gj+1];
            end
         end
      end
   end

   // Magnitude of the angle, then rounding to the output fraction.
   assign ang = z_ff[CORDIC_ITERS];

   always_ff @(posedge clock) begin
      if (en) begin
         abs_ff <= ang[63] ? 64'(-ang) : 64'(ang);
         neg_ff <= ang[63];
      end
   end

   always_comb begin
      rr  = (abs_ff + HALF) >> SH;
      r16 = rr[PHASE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= vld_ff[LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_ff[LAST]) begin
            out_phase_ff <= '0;
         end else begin
            out_phase_ff <= neg_ff ? -r16 : r16;
         end
         out_amp_ff <= sat_ff[LAST] ? AMP_MAX : root_ff[LAST];
         out_bg_ff  <= bg_ff[LAST];
      end
   end

endmodule
`default_nettype wire

// File: rtl/phase_shift_interferometry_pixel.sv
// Top level of the per-pixel phase-shifting interferometry block.
//
// The req stream carries one pixel per transfer: seven intensity samples in
// tdata, sample0 in the lowest bits. The rsp stream returns one transfer per
// pixel with the wrapped phase, the modulation amplitude and the background.
// The csr channel writes the step count, which picks the formula; it is
// always ready and should be written only while no pixel is in flight.
// A pixel moves from the input queue through a two-stage setup, one register
// stage per CORDIC iteration (sixty of them), a rounding stage and the output
// register. The integer square root runs beside the CORDIC in thirty stages
// of its own. One pixel per cycle is sustained while the receiver keeps
// rsp_tready high.
// While a result is offered and rsp_tready is low, the whole back pipeline
// holds; the front keeps taking pixels into a four-entry queue and drops
// req_tready once it is full. Synchronous reset empties the queue and the
// pipeline and sets the step count to four.
`timescale 1ns / 1ps
`default_nettype none
module phase_shift_interferometry_pixel #(
   parameter int SAMPLE_BITS     = pis_pkg::SAMPLE_BITS_DEF,
   parameter int PHASE_FRAC_BITS = pis_pkg::PHASE_FRAC_BITS_DEF
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   csr_valid,
   output logic                                                   csr_ready,
   input  logic [pis_pkg::STEP_W-1:0]                             csr_data,
   input  logic                                                   req_tvalid,
   output logic                                                   req_tready,
   // sample0, sample1, ..., sample6, then zero fill
   input  logic [((pis_pkg::NUM_SAMPLES*SAMPLE_BITS+7)/8)*8-1:0]  req_tdata,
   output logic                                                   rsp_tvalid,
   input  logic                                                   rsp_tready,
   // phase, amplitude, background
   output logic [pis_pkg::RSP_W-1:0]                              rsp_tdata
);
   import pis_pkg::*;

   localparam int NW = SAMPLE_BITS + 4;
   localparam int QW = 2 * NW + BG_W + 1;

   logic signed [NW-1:0] f_num;
   logic signed [NW-1:0] f_den;
   logic [BG_W-1:0]      f_bg;
   logic                 f_mode7;
   logic [QW-1:0]        q_data;
   logic                 q_valid;
   logic                 q_ready;
   logic [PHASE_W-1:0]   b_phase;
   logic [AMP_W-1:0]     b_amp;
   logic [BG_W-1:0]      b_bg;

   pis_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .samples   (req_tdata[NUM_SAMPLES*SAMPLE_BITS-1:0]),
      .num       (f_num),
      .den       (f_den),
      .bg        (f_bg),
      .mode7     (f_mode7)
   );

   pis_fifo #(
      .WIDTH (QW)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_data  ({f_mode7, f_bg, f_den, f_num}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   pis_back #(
      .SAMPLE_BITS     (SAMPLE_BITS),
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_num    (q_data[NW-1:0]),
      .in_den    (q_data[2*NW-1:NW]),
      .in_bg     (q_data[2*NW +: BG_W]),
      .in_mode7  (q_data[QW-1]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_phase (b_phase),
      .out_amp   (b_amp),
      .out_bg    (b_bg)
   );

   assign rsp_tdata = {b_bg, b_amp, b_phase};

endmodule
`default_nettype wire

// File: rtl/pis_checker.sv
// Port-level checks of the interferometry pixel block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module pis_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [pis_pkg::RSP_W-1:0]   rsp_tdata
);

   // The pipeline empties on reset, so nothing is offered right after it.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // The input queue is empty after reset and must take a transfer.
   a_reset_ready: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

endmodule

bind phase_shift_interferometry_pixel pis_checker u_pis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// File: test/tb_phase_shift_interferometry_pixel.sv
// Self-checking stream testbench for the phase-shifting interferometry pixel block.
`timescale 1ns / 1ps
module tb_phase_shift_interferometry_pixel;
   import pis_pkg::*;

   localparam int REQ_W = ((NUM_SAMPLES * 16 + 7) / 8) * 8;
   localparam int LIMIT_CYCLES = 400000;

   typedef logic [15:0] pixel_type [NUM_SAMPLES];

   typedef struct {
      logic signed [PHASE_W-1:0] phase;
      logic [AMP_W-1:0]          amplitude;
      logic [BG_W-1:0]           background;
   } pixel_result_type;

   class pixel_scoreboard;
      pixel_result_type   pending_q[$];
      logic [STEP_W-1:0]  step_reg;
      longint             arctan_tab[CORDIC_ITERS];
      int                 mismatches;
      longint             pi_q60;

      function new();
         longint unsigned p, sum, k, term;
         pi_q60 = 64'sh3243F6A8885A308D;
         step_reg = STEP_RESET;
         mismatches = 0;
         arctan_tab[0] = (pi_q60 + 2) / 4;
         for (int i = 1; i < CORDIC_ITERS; i++) begin
            p = 64'd1 << (62 - i);
            sum = 0;
            k = 0;
            while (p != 0) begin
               term = p / (2 * k + 1);
               if (!k[0]) sum = sum + term;
               else sum = sum - term;
               if (2 * i >= 64) p = 0;
               else p = p >> (2 * i);
               k++;
            end
            arctan_tab[i] = longint'((sum + 2) >> 2);
         end
      endfunction

      function longint shr_mag(longint v, int s);
         return v >= 0 ? (v >>> s) : -((-v) >>> s);
      endfunction

      function longint arctan2(longint y, longint x);
         longint off, z, m, ay, dx, dy;
         off = 0;
         z = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            off = (y >= 0) ? pi_q60 : -pi_q60;
            x = -x;
            y = -y;
         end
         ay = (y < 0) ? -y : y;
         m = (x > ay) ? x : ay;
         while (m < (64'sd1 <<< 58)) begin
            m = m * 2;
            x = x * 2;
            y = y * 2;
         end
         for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = shr_mag(y, i);
            dy = shr_mag(x, i);
            if (y > 0) begin
               x = x + dx;
               y = y - dy;
               z = z + arctan_tab[i];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - arctan_tab[i];
            end
         end
         return off + z;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function longint unsigned capped_mul(longint unsigned a, longint unsigned w);
         longint unsigned lim;
         lim = 64'd1 << 60;
         if (a > lim / w) return lim;
         return a * w;
      endfunction

      function void note_pixel(pixel_type px);
         longint s[NUM_SAMPLES];
         longint num, den, ang;
         longint unsigned bg2, bg, n2, d2, sq, amp, r;
         logic [STEP_W-1:0] mode;
         pixel_result_type e;
         for (int i = 0; i < NUM_SAMPLES; i++) s[i] = longint'(px[i]);
         mode = (step_reg < STEP_3) ? STEP_3 : step_reg;
         case (mode)
            STEP_7: begin
               num = 4 * s[1] - 8 * s[3] + 4 * s[5];
               den = -s[0] + 7 * s[2] - 7 * s[4] + s[6];
               bg2 = s[0] + s[1] + s[2] + s[4] + s[5] + s[6] + 2 * s[3];
            end
            STEP_6: begin
               num = -3 * s[1] + 4 * s[3] - s[5];
               den = s[0] - 4 * s[2] + 3 * s[4];
               bg2 = s[0] + s[1] + s[4] + s[5] + 2 * (s[2] + s[3]);
            end
            STEP_5: begin
               num = 2 * (s[1] - s[3]);
               den = 2 * s[2] - s[4] - s[0];
               bg2 = s[0] + s[4] + 2 * (s[1] + s[2] + s[3]);
            end
            STEP_4: begin
               num = s[1] - s[3];
               den = s[2] - s[0];
               bg2 = 2 * (s[0] + s[1] + s[2] + s[3]);
            end
            default: begin
               num = s[2] - s[1];
               den = s[0] - s[1];
               bg2 = 0;
            end
         endcase
         if (mode == STEP_3) bg = (8 * longint'(s[0] + s[1] + s[2]) + 3) / 6;
         else bg = (bg2 + 1) >> 1;
         if (bg > BG_MAX) bg = BG_MAX;
         n2 = (num < 0) ? -num : num;
         d2 = (den < 0) ? -den : den;
         n2 = n2 * n2;
         d2 = d2 * d2;
         if (mode == STEP_7) sq = capped_mul(n2, 1000000) + capped_mul(d2, 500000);
         else sq = capped_mul(n2, 1) + capped_mul(d2, 1);
         if (sq >= (64'd1 << 60)) amp = AMP_MAX;
         else amp = int_sqrt(sq);
         if (amp > AMP_MAX) amp = AMP_MAX;
         ang = arctan2(num, den);
         r = (ang < 0) ? -ang : ang;
         r = (r + (64'd1 << 46)) >> 47;
         e.phase = (ang < 0) ? -r[15:0] : r[15:0];
         e.amplitude = amp[AMP_W-1:0];
         e.background = bg[BG_W-1:0];
         pending_q = {pending_q, e};
      endfunction

      function void check_result(logic [RSP_W-1:0] d);
         pixel_result_type e;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer %h", d);
            return;
         end
         e = pending_q.pop_front();
         if (d[15:0] !== e.phase || d[45:16] !== e.amplitude || d[63:46] !== e.background) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result error: phase %0d/%0d amplitude %0d/%0d background %0d/%0d",
                        $signed(d[15:0]), e.phase, d[45:16], e.amplitude,
                        d[63:46], e.background);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [STEP_W-1:0]     csr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;

   pixel_scoreboard sb;
   bit              no_idle;
   int              rsp_hold;
   int              cycles;

   phase_shift_interferometry_pixel dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= LIMIT_CYCLES) begin
            $display("phase_shift_interferometry_pixel: mismatch");
            $finish;
         end
      end
   end

   task automatic write_step(logic [STEP_W-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.step_reg = v;
   endtask

   task automatic send_pixel(pixel_type px);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      for (int i = 0; i < NUM_SAMPLES; i++) req_tdata[i*16 +: 16] <= px[i];
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(px);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic pixel_type random_pixel();
      pixel_type px;
      int kind;
      kind = $urandom_range(0, 3);
      for (int i = 0; i < NUM_SAMPLES; i++) begin
         case (kind)
            0: px[i] = $urandom_range(0, 15);
            1: px[i] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2: px[i] = 16'h8000 + $urandom_range(0, 255) - 128;
            default: px[i] = $urandom;
         endcase
      end
      return px;
   endfunction

   initial begin
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         int stall;
         stall = (rsp_hold > 0) ? rsp_hold : (no_idle ? 0 : $urandom_range(0, 13));
         rsp_hold = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   end

   initial begin
      logic [STEP_W-1:0] steps[8];
      pixel_type px;
      sb = new();
      no_idle = 1'b0;
      rsp_hold = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      steps = '{STEP_4, STEP_3, STEP_5, STEP_6, STEP_7, 3'd0, 3'd1, 3'd2};
      foreach (steps[n]) begin
         if (n > 0) write_step(steps[n]);
         foreach (px[i]) px[i] = 16'h0000;
         send_pixel(px);
         foreach (px[i]) px[i] = 16'hFFFF;
         send_pixel(px);
         foreach (px[i]) px[i] = 16'h0000;
         case ((steps[n] < STEP_3) ? STEP_3 : steps[n])
            STEP_3: begin px[1] = 16'hFFFF; px[2] = 16'hFFFF; end
            STEP_6: px[2] = 16'hFFFF;
            default: px[0] = 16'hFFFF;
         endcase
         send_pixel(px);
         drain();
      end

      for (int ph = 0; ph < 10; ph++) begin
         write_step(ph < 5 ? steps[(ph + 1) % 5] : 3'($urandom_range(0, 7)));
         no_idle = (ph % 3 == 1);
         for (int n = 0; n < 140; n++) begin
            if (ph == 2 && n == 20) rsp_hold = 300;
            if (ph == 6 && n == 70) drain();
            send_pixel(random_pixel());
         end
         drain();
      end
      no_idle = 1'b0;

      repeat (70) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("phase_shift_interferometry_pixel: match");
      end else begin
         $display("phase_shift_interferometry_pixel: mismatch");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/pis_pkg.sv
rtl/pis_front.sv
rtl/pis_fifo.sv
rtl/pis_back.sv
rtl/phase_shift_interferometry_pixel.sv
rtl/pis_checker.sv
test/tb_phase_shift_interferometry_pixel.sv
